>>> hdl/quadratic_bspline_basis_eval_top_assert.svh
// Assertion macros for the checker file of the B-spline basis evaluator.
`ifndef QUADRATIC_BSPLINE_BASIS_EVAL_TOP_ASSERT_SVH
`define QUADRATIC_BSPLINE_BASIS_EVAL_TOP_ASSERT_SVH

// Check at every rising edge, reset included.
`define QBSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check at every rising edge outside reset.
`define QBSP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> hdl/qbsp_pkg.sv
// Shared constants, types and divider step functions of the B-spline basis evaluator.
package qbsp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int KNOT_W    = 32;
    localparam int DIFF_W    = KNOT_W + 1;
    localparam int SUM_W     = KNOT_W + 3;
    localparam int DEN_W     = KNOT_W;
    localparam int REM_W     = DEN_W + 1;
    localparam int Q1_W      = FRAC_BITS + 1;
    localparam int L1_N      = Q1_W;
    localparam int LANES     = 6;
    localparam int PROD_W    = 2 * Q1_W;
    localparam int S_W       = Q1_W + 2;
    localparam int X_W       = FRAC_BITS + 2;
    localparam int DVD_W     = X_W + FRAC_BITS;
    localparam int L2_N      = DVD_W;
    localparam int VAL_W     = FRAC_BITS + 2;
    localparam int SAT_W     = (DVD_W > 33) ? DVD_W : 33;
    localparam int VALUE_W   = 17;
    localparam int SLOPE_W   = 32;
    localparam int IDX_W     = 2;

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [S_W-1:0]    ssum_t;
    typedef logic [REM_W-1:0]         rem_t;
    typedef logic [SAT_W-1:0]         sat_t;
    typedef logic [VAL_W-1:0]         val_t;

    typedef enum logic [1:0] {
        SEG_NONE,
        SEG_RISE,
        SEG_MID,
        SEG_FALL
    } seg_t;

    typedef enum logic [IDX_W-1:0] {
        REG_KNOT_ZERO,
        REG_KNOT_ONE,
        REG_KNOT_TWO,
        REG_KNOT_THREE
    } knot_idx_t;

    typedef struct packed {
        rem_t             rem;
        logic [DEN_W-1:0] den;
        logic [Q1_W-1:0]  quo;
    } div1_t;

    typedef struct packed {
        logic valid;
        logic bad;
        seg_t seg;
        logic s1_neg;
        logic s2_neg;
    } side1_t;

    typedef struct packed {
        logic valid;
        logic bad;
        seg_t seg;
        logic neg;
    } side_pm_t;

    typedef struct packed {
        rem_t             rem;
        logic [DEN_W-1:0] den;
        logic [DVD_W-1:0] dvd;
        logic [DVD_W-1:0] quo;
    } div2_t;

    typedef struct packed {
        logic valid;
        logic bad;
        logic neg;
        val_t value;
    } side2_t;

    // One quotient bit of a fraction divide; the first step takes the integer bit.
    function automatic div1_t div1_step(input div1_t cur, input logic first);
        rem_t  rr;
        logic  bit_q;
        div1_t nxt;
        rr       = first ? cur.rem : {cur.rem[REM_W-2:0], 1'b0};
        bit_q    = (rr >= {1'b0, cur.den});
        nxt.den  = cur.den;
        nxt.rem  = bit_q ? (rr - {1'b0, cur.den}) : rr;
        nxt.quo  = {cur.quo[Q1_W-2:0], bit_q};
        return nxt;
    endfunction

    // One quotient bit of long division, bringing down the next dividend bit.
    function automatic div2_t div2_step(input div2_t cur);
        rem_t  rr;
        logic  bit_q;
        div2_t nxt;
        rr       = {cur.rem[REM_W-2:0], cur.dvd[DVD_W-1]};
        bit_q    = (rr >= {1'b0, cur.den});
        nxt.den  = cur.den;
        nxt.rem  = bit_q ? (rr - {1'b0, cur.den}) : rr;
        nxt.dvd  = {cur.dvd[DVD_W-2:0], 1'b0};
        nxt.quo  = {cur.quo[DVD_W-2:0], bit_q};
        return nxt;
    endfunction

endpackage

>>> hdl/quadratic_bspline_basis_eval_top.sv
// Top level of the quadratic B-spline basis evaluator: knot registers and the full pipeline.
//
// Evaluates one quadratic B-spline basis function, set by four knots, and its
// derivative at each position beat; positions and slope are signed Q16.16 and
// the value is unsigned Q1.16. One beat enters per cycle while in_stall is low,
// and the pipeline holds up to 3*FRAC_BITS+8 beats in flight, one per register
// stage.
// Most of the depth comes from two chains of restoring divide stages, one quotient
// bit per stage: six parallel fraction dividers of FRAC_BITS+1 stages for the
// piece ratios, then one slope divider of 2*FRAC_BITS+2 stages. The whole
// pipeline advances together; it freezes only while a result beat sits in the
// output register with out_stall high, and in_stall follows exactly that.
// Knots are written through cfg_wr_en/cfg_index/cfg_data and must only change
// while no beat is in flight. Knots that are not strictly increasing give
// zero value and slope with knots_invalid set.
module quadratic_bspline_basis_eval_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [qbsp_pkg::IDX_W-1:0]          cfg_index,
    input  logic [qbsp_pkg::KNOT_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [qbsp_pkg::KNOT_W-1:0]  position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [qbsp_pkg::VALUE_W-1:0]        basis_value,
    output logic signed [qbsp_pkg::SLOPE_W-1:0] basis_slope,
    output logic                                knots_invalid
);

    // Knot registers
    logic signed [qbsp_pkg::KNOT_W-1:0] knot_zero_reg;
    logic signed [qbsp_pkg::KNOT_W-1:0] knot_one_reg;
    logic signed [qbsp_pkg::KNOT_W-1:0] knot_two_reg;
    logic signed [qbsp_pkg::KNOT_W-1:0] knot_three_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knot_zero_reg  <= '0;
            knot_one_reg   <= qbsp_pkg::KNOT_W'(1) << qbsp_pkg::FRAC_BITS;
            knot_two_reg   <= qbsp_pkg::KNOT_W'(2) << qbsp_pkg::FRAC_BITS;
            knot_three_reg <= qbsp_pkg::KNOT_W'(3) << qbsp_pkg::FRAC_BITS;
        end
        else if (cfg_wr_en)
        begin
            unique case (qbsp_pkg::knot_idx_t'(cfg_index))
                qbsp_pkg::REG_KNOT_ZERO:  knot_zero_reg  <= cfg_data;
                qbsp_pkg::REG_KNOT_ONE:   knot_one_reg   <= cfg_data;
                qbsp_pkg::REG_KNOT_TWO:   knot_two_reg   <= cfg_data;
                qbsp_pkg::REG_KNOT_THREE: knot_three_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: hold everything while the output beat is refused.
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = out_valid && out_stall;

    // Knot differences; knots stay fixed while beats are in flight.
    qbsp_pkg::diff_t d10, d20, d21, d31, d32;
    logic            bad;
    assign d10 = qbsp_pkg::diff_t'(knot_one_reg)   - qbsp_pkg::diff_t'(knot_zero_reg);
    assign d20 = qbsp_pkg::diff_t'(knot_two_reg)   - qbsp_pkg::diff_t'(knot_zero_reg);
    assign d21 = qbsp_pkg::diff_t'(knot_two_reg)   - qbsp_pkg::diff_t'(knot_one_reg);
    assign d31 = qbsp_pkg::diff_t'(knot_three_reg) - qbsp_pkg::diff_t'(knot_one_reg);
    assign d32 = qbsp_pkg::diff_t'(knot_three_reg) - qbsp_pkg::diff_t'(knot_two_reg);
    assign bad = !(knot_zero_reg < knot_one_reg && knot_one_reg < knot_two_reg
                   && knot_two_reg < knot_three_reg);

    // Stage 0: input register
    logic                               s0_valid_reg;
    logic signed [qbsp_pkg::KNOT_W-1:0] s0_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s0_pos_reg <= position;
    end

    // Prep: pick the piece and load the six fraction dividers.
    qbsp_pkg::diff_t tk0, k2t, k3t, tk1;
    qbsp_pkg::sum_t  n1, n2, n1_abs, n2_abs;
    assign tk0 = qbsp_pkg::diff_t'(s0_pos_reg) - qbsp_pkg::diff_t'(knot_zero_reg);
    assign tk1 = qbsp_pkg::diff_t'(s0_pos_reg) - qbsp_pkg::diff_t'(knot_one_reg);
    assign k2t = qbsp_pkg::diff_t'(knot_two_reg) - qbsp_pkg::diff_t'(s0_pos_reg);
    assign k3t = qbsp_pkg::diff_t'(knot_three_reg) - qbsp_pkg::diff_t'(s0_pos_reg);
    assign n1  = qbsp_pkg::sum_t'(knot_zero_reg) + qbsp_pkg::sum_t'(knot_two_reg)
               - (qbsp_pkg::sum_t'(s0_pos_reg) <<< 1);
    assign n2  = qbsp_pkg::sum_t'(knot_one_reg) + qbsp_pkg::sum_t'(knot_three_reg)
               - (qbsp_pkg::sum_t'(s0_pos_reg) <<< 1);
    assign n1_abs = n1[qbsp_pkg::SUM_W-1] ? -n1 : n1;
    assign n2_abs = n2[qbsp_pkg::SUM_W-1] ? -n2 : n2;

    qbsp_pkg::div1_t  l1_reg  [qbsp_pkg::L1_N+1][qbsp_pkg::LANES];
    qbsp_pkg::div1_t  l1_next [qbsp_pkg::L1_N+1][qbsp_pkg::LANES];
    qbsp_pkg::side1_t sb1_reg  [qbsp_pkg::L1_N+1];
    qbsp_pkg::side1_t sb1_next [qbsp_pkg::L1_N+1];
    qbsp_pkg::seg_t   seg;

    always_comb
    begin
        if (bad)
            seg = qbsp_pkg::SEG_NONE;
        else if (s0_pos_reg >= knot_zero_reg && s0_pos_reg < knot_one_reg)
            seg = qbsp_pkg::SEG_RISE;
        else if (s0_pos_reg >= knot_one_reg && s0_pos_reg < knot_two_reg)
            seg = qbsp_pkg::SEG_MID;
        else if (s0_pos_reg >= knot_two_reg && s0_pos_reg < knot_three_reg)
            seg = qbsp_pkg::SEG_FALL;
        else
            seg = qbsp_pkg::SEG_NONE;
    end

    always_comb
    begin
        // Idle lanes divide zero by one.
        for (int k = 0; k < qbsp_pkg::LANES; k++)
        begin
            l1_next[0][k].rem = '0;
            l1_next[0][k].den = qbsp_pkg::DEN_W'(1);
            l1_next[0][k].quo = '0;
        end
        unique case (seg)
            qbsp_pkg::SEG_RISE:
            begin
                l1_next[0][0].rem = {1'b0, tk0[qbsp_pkg::DEN_W-1:0]};
                l1_next[0][0].den = d10[qbsp_pkg::DEN_W-1:0];
                l1_next[0][1].rem = {1'b0, tk0[qbsp_pkg::DEN_W-1:0]};
                l1_next[0][1].den = d20[qbsp_pkg::DEN_W-1:0];
            end
            qbsp_pkg::SEG_MID:
            begin
                l1_next[0][0].rem = {1'b0, tk0[qbsp_pkg::DEN_W-1:0]};
                l1_next[0][0].den = d20[qbsp_pkg::DEN_W-1:0];
                l1_next[0][1].rem = {1'b0, k2t[qbsp_pkg::DEN_W-1:0]};
                l1_next[0][1].den = d21[qbsp_pkg::DEN_W-1:0];
                l1_next[0][2].rem = {1'b0, k3t[qbsp_pkg::DEN_W-1:0]};
                l1_next[0][2].den = d31[qbsp_pkg::DEN_W-1:0];
                l1_next[0][3].rem = {1'b0, tk1[qbsp_pkg::DEN_W-1:0]};
                l1_next[0][3].den = d21[qbsp_pkg::DEN_W-1:0];
                l1_next[0][4].rem = {1'b0, n1_abs[qbsp_pkg::DEN_W-1:0]};
                l1_next[0][4].den = d20[qbsp_pkg::DEN_W-1:0];
                l1_next[0][5].rem = {1'b0, n2_abs[qbsp_pkg::DEN_W-1:0]};
                l1_next[0][5].den = d31[qbsp_pkg::DEN_W-1:0];
            end
            qbsp_pkg::SEG_FALL:
            begin
                l1_next[0][0].rem = {1'b0, k3t[qbsp_pkg::DEN_W-1:0]};
                l1_next[0][0].den = d32[qbsp_pkg::DEN_W-1:0];
                l1_next[0][1].rem = {1'b0, k3t[qbsp_pkg::DEN_W-1:0]};
                l1_next[0][1].den = d31[qbsp_pkg::DEN_W-1:0];
            end
            default: ;
        endcase
        sb1_next[0].valid  = s0_valid_reg;
        sb1_next[0].bad    = bad;
        sb1_next[0].seg    = seg;
        sb1_next[0].s1_neg = n1[qbsp_pkg::SUM_W-1];
        sb1_next[0].s2_neg = n2[qbsp_pkg::SUM_W-1];
        // Fraction divider stages, one quotient bit each
        for (int j = 0; j < qbsp_pkg::L1_N; j++)
        begin
            for (int k = 0; k < qbsp_pkg::LANES; k++)
                l1_next[j+1][k] = qbsp_pkg::div1_step(l1_reg[j][k], j == 0);
            sb1_next[j+1] = sb1_reg[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= qbsp_pkg::L1_N; j++)
                sb1_reg[j] <= '0;
        end
        else if (adv)
            sb1_reg <= sb1_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            l1_reg <= l1_next;
    end

    // Products and slope numerator
    logic [qbsp_pkg::Q1_W-1:0] q0, q1, q2, q3, q4, q5;
    qbsp_pkg::ssum_t           s1, s2, s_sum, s_abs;
    qbsp_pkg::side1_t          sb_last;
    qbsp_pkg::side_pm_t        pm_side_reg, pm_side_next;
    logic [qbsp_pkg::PROD_W-1:0] p01_reg, p23_reg;
    logic [qbsp_pkg::X_W-1:0]    x_reg, x_next;

    assign sb_last = sb1_reg[qbsp_pkg::L1_N];
    assign q0 = l1_reg[qbsp_pkg::L1_N][0].quo;
    assign q1 = l1_reg[qbsp_pkg::L1_N][1].quo;
    assign q2 = l1_reg[qbsp_pkg::L1_N][2].quo;
    assign q3 = l1_reg[qbsp_pkg::L1_N][3].quo;
    assign q4 = l1_reg[qbsp_pkg::L1_N][4].quo;
    assign q5 = l1_reg[qbsp_pkg::L1_N][5].quo;
    assign s1 = sb_last.s1_neg ? -qbsp_pkg::ssum_t'(q4) : qbsp_pkg::ssum_t'(q4);
    assign s2 = sb_last.s2_neg ? -qbsp_pkg::ssum_t'(q5) : qbsp_pkg::ssum_t'(q5);
    assign s_sum = s1 + s2;
    assign s_abs = s_sum[qbsp_pkg::S_W-1] ? -s_sum : s_sum;

    always_comb
    begin
        pm_side_next.valid = sb_last.valid;
        pm_side_next.bad   = sb_last.bad;
        pm_side_next.seg   = sb_last.seg;
        pm_side_next.neg   = 1'b0;
        x_next             = {q0, 1'b0};
        unique case (sb_last.seg)
            qbsp_pkg::SEG_MID:
            begin
                x_next           = s_abs[qbsp_pkg::X_W-1:0];
                pm_side_next.neg = s_sum[qbsp_pkg::S_W-1];
            end
            qbsp_pkg::SEG_FALL: pm_side_next.neg = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pm_side_reg <= '0;
        else if (adv)
            pm_side_reg <= pm_side_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p01_reg <= q0 * q1;
            p23_reg <= q2 * q3;
            x_reg   <= x_next;
        end
    end

    // Value sum and slope divider load
    qbsp_pkg::div2_t  l2_reg  [qbsp_pkg::L2_N+1];
    qbsp_pkg::div2_t  l2_next [qbsp_pkg::L2_N+1];
    qbsp_pkg::side2_t sb2_reg  [qbsp_pkg::L2_N+1];
    qbsp_pkg::side2_t sb2_next [qbsp_pkg::L2_N+1];

    always_comb
    begin
        l2_next[0].rem = '0;
        l2_next[0].quo = '0;
        l2_next[0].dvd = {x_reg, {qbsp_pkg::FRAC_BITS{1'b0}}};
        unique case (pm_side_reg.seg)
            qbsp_pkg::SEG_RISE: l2_next[0].den = d20[qbsp_pkg::DEN_W-1:0];
            qbsp_pkg::SEG_MID:  l2_next[0].den = d21[qbsp_pkg::DEN_W-1:0];
            qbsp_pkg::SEG_FALL: l2_next[0].den = d31[qbsp_pkg::DEN_W-1:0];
            default:            l2_next[0].den = qbsp_pkg::DEN_W'(1);
        endcase
        sb2_next[0].valid = pm_side_reg.valid;
        sb2_next[0].bad   = pm_side_reg.bad;
        sb2_next[0].neg   = pm_side_reg.neg;
        sb2_next[0].value = qbsp_pkg::val_t'(p01_reg >> qbsp_pkg::FRAC_BITS)
                          + qbsp_pkg::val_t'(p23_reg >> qbsp_pkg::FRAC_BITS);
        // Slope divider stages, one quotient bit each
        for (int j = 0; j < qbsp_pkg::L2_N; j++)
        begin
            l2_next[j+1]  = qbsp_pkg::div2_step(l2_reg[j]);
            sb2_next[j+1] = sb2_reg[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= qbsp_pkg::L2_N; j++)
                sb2_reg[j] <= '0;
        end
        else if (adv)
            sb2_reg <= sb2_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            l2_reg <= l2_next;
    end

    // Saturate the slope and drive the output register.
    qbsp_pkg::side2_t               sb2_last;
    qbsp_pkg::sat_t                 qx, qx_neg;
    logic signed [qbsp_pkg::SLOPE_W-1:0] slope_next;
    logic signed [qbsp_pkg::SLOPE_W-1:0] slope_reg;
    logic [qbsp_pkg::VALUE_W-1:0]   value_reg;
    logic                           bad_reg;
    logic                           out_valid_reg;

    assign sb2_last = sb2_reg[qbsp_pkg::L2_N];
    assign qx       = qbsp_pkg::sat_t'(l2_reg[qbsp_pkg::L2_N].quo);
    assign qx_neg   = ~qx + qbsp_pkg::sat_t'(1);

    always_comb
    begin
        if (sb2_last.neg)
        begin
            if (qx > qbsp_pkg::sat_t'(32'h8000_0000))
                slope_next = {1'b1, {(qbsp_pkg::SLOPE_W-1){1'b0}}};
            else
                slope_next = qx_neg[qbsp_pkg::SLOPE_W-1:0];
        end
        else
        begin
            if (qx > qbsp_pkg::sat_t'(32'h7FFF_FFFF))
                slope_next = {1'b0, {(qbsp_pkg::SLOPE_W-1){1'b1}}};
            else
                slope_next = qx[qbsp_pkg::SLOPE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= sb2_last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg <= qbsp_pkg::VALUE_W'(sb2_last.value);
            slope_reg <= slope_next;
            bad_reg   <= sb2_last.bad;
        end
    end

    assign out_valid     = out_valid_reg;
    assign basis_value   = value_reg;
    assign basis_slope   = slope_reg;
    assign knots_invalid = bad_reg;

endmodule

>>> hdl/qbsp_checker.sv
// Port-level checker of the B-spline basis evaluator and its bind.
`include "quadratic_bspline_basis_eval_top_assert.svh"

module qbsp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [qbsp_pkg::VALUE_W-1:0]        basis_value,
    input logic signed [qbsp_pkg::SLOPE_W-1:0] basis_slope,
    input logic                                knots_invalid
);

    logic                                          out_stuck;
    logic                                          zero_beat;
    logic [qbsp_pkg::VALUE_W+qbsp_pkg::SLOPE_W:0] beat_bits;

    assign out_stuck = out_valid && out_stall;
    assign zero_beat = (basis_value == '0) && (basis_slope == '0);
    assign beat_bits = {basis_value, basis_slope, knots_invalid};

    // No result beat while in reset.
    `QBSP_ASSERT(a_rst_quiet, !rst_n |-> !out_valid, "result beat during reset")

    // A refused result beat holds.
    `QBSP_ASSERT_RST(a_out_hold, out_stuck |=> out_valid && $stable(beat_bits), "held beat moved")

    // Bad knots always come with zero value and slope.
    `QBSP_ASSERT_RST(a_bad_zero, out_valid && knots_invalid |-> zero_beat, "bad knots, nonzero beat")

    // The input side only stalls behind a refused result beat.
    `QBSP_ASSERT_RST(a_in_free, !out_stuck |-> !in_stall, "input stalled without cause")

endmodule

bind quadratic_bspline_basis_eval_top qbsp_checker u_qbsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .basis_value   (basis_value),
    .basis_slope   (basis_slope),
    .knots_invalid (knots_invalid)
);

>>> bench/tb_top.sv
// Self-checking bench for the quadratic B-spline basis evaluator: directed and random positions.
`timescale 1ns / 1ps

module tb_top;

    // One result beat: value, slope and the bad-knot flag.
    typedef struct {
        logic [qbsp_pkg::VALUE_W-1:0]        value;
        logic signed [qbsp_pkg::SLOPE_W-1:0] slope;
        logic                                bad;
    } basis_t;

    // One directed row: a position and, where it is obvious, the typed-in answer.
    typedef struct {
        logic signed [qbsp_pkg::KNOT_W-1:0] pos;
        bit                                 typed;
        basis_t                             ans;
    } row_t;

    localparam int LATENCY   = 3 * qbsp_pkg::FRAC_BITS + 7;
    localparam int HOLD_LEN  = 200;
    localparam int WDOG_MAX  = 4000;
    localparam longint SMAX  = 64'sd2147483647;
    localparam longint SMIN  = -64'sd2147483648;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_wr_en;
    logic [qbsp_pkg::IDX_W-1:0]          cfg_index;
    logic [qbsp_pkg::KNOT_W-1:0]         cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [qbsp_pkg::KNOT_W-1:0]  position;
    logic                                out_valid;
    logic                                out_stall;
    logic [qbsp_pkg::VALUE_W-1:0]        basis_value;
    logic signed [qbsp_pkg::SLOPE_W-1:0] basis_slope;
    logic                                knots_invalid;

    quadratic_bspline_basis_eval_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .position      (position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .basis_value   (basis_value),
        .basis_slope   (basis_slope),
        .knots_invalid (knots_invalid)
    );

    // Bench copy of the knot registers, signed, widened for the arithmetic.
    longint knot_q [4];
    basis_t pending_basis [$];

    int  beats_sent;
    int  beats_checked;
    int  errors;
    int  bad_phases;
    int  knot_sets;
    int  quiet_cycles;
    bit  idle_on;
    bit  held;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Truncating fraction: num * 2^F / den, rounding toward zero.
    function automatic longint frac_div(input longint num, input longint den);
        return (num * (64'sd1 <<< qbsp_pkg::FRAC_BITS)) / den;
    endfunction

    function automatic longint fx_mul(input longint x, input longint y);
        return (x * y) / (64'sd1 <<< qbsp_pkg::FRAC_BITS);
    endfunction

    // Basis value and slope at position t under the current knots.
    function automatic basis_t eval_basis(input logic signed [qbsp_pkg::KNOT_W-1:0] pos);
        longint k0, k1, k2, k3, t, one, val, slp, u, w, r, s;
        longint d10, d20, d21, d31, d32;
        basis_t res;
        k0  = knot_q[0];
        k1  = knot_q[1];
        k2  = knot_q[2];
        k3  = knot_q[3];
        t   = pos;
        one = 64'sd1 <<< qbsp_pkg::FRAC_BITS;
        val = 0;
        slp = 0;
        res.bad = 1'b0;
        if (!(k0 < k1 && k1 < k2 && k2 < k3))
        begin
            res.bad = 1'b1;
        end
        else
        begin
            d10 = k1 - k0;
            d20 = k2 - k0;
            d21 = k2 - k1;
            d31 = k3 - k1;
            d32 = k3 - k2;
            if (t >= k0 && t < k1)
            begin
                u   = frac_div(t - k0, d10);
                w   = frac_div(t - k0, d20);
                val = fx_mul(u, w);
                slp = (2 * u * one) / d20;
            end
            else if (t >= k1 && t < k2)
            begin
                val = fx_mul(frac_div(t - k0, d20), frac_div(k2 - t, d21))
                    + fx_mul(frac_div(k3 - t, d31), frac_div(t - k1, d21));
                s   = frac_div(k0 + k2 - 2 * t, d20) + frac_div(k1 + k3 - 2 * t, d31);
                slp = (s * one) / d21;
            end
            else if (t >= k2 && t < k3)
            begin
                r   = frac_div(k3 - t, d32);
                val = fx_mul(r, frac_div(k3 - t, d31));
                slp = -((2 * r * one) / d31);
            end
            if (slp > SMAX) slp = SMAX;
            if (slp < SMIN) slp = SMIN;
        end
        res.value = val[qbsp_pkg::VALUE_W-1:0];
        res.slope = slp[qbsp_pkg::SLOPE_W-1:0];
        return res;
    endfunction

    // Drop the input, drain the pipeline, then write all four knots.
    task automatic load_knots(input longint a, input longint b, input longint c,
                              input longint d);
        qbsp_pkg::knot_idx_t idx;
        longint              vals [4];
        vals = '{a, b, c, d};
        in_valid <= 1'b0;
        wait (pending_basis.size() == 0);
        @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            idx = qbsp_pkg::knot_idx_t'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i][qbsp_pkg::KNOT_W-1:0];
            @(posedge clk);
            knot_q[i] = longint'($signed(vals[i][qbsp_pkg::KNOT_W-1:0]));
        end
        cfg_wr_en <= 1'b0;
        knot_sets++;
        if (!(knot_q[0] < knot_q[1] && knot_q[1] < knot_q[2] && knot_q[2] < knot_q[3]))
            bad_phases++;
    endtask

    // Offer one position beat, optionally after a random gap, and hold it until taken.
    task automatic send_pos(input logic signed [qbsp_pkg::KNOT_W-1:0] pos, input bit typed,
                            input basis_t ans);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        position <= pos;
        do @(posedge clk); while (in_stall);
        pending_basis.push_back(typed ? ans : eval_basis(pos));
        beats_sent++;
    endtask

    // Random knot set: tiny, moderate or wide spacing, extremes, and now and then a bad order.
    task automatic random_knots(input int kind);
        longint base, g1, g2, g3, tmp [4];
        case (kind)
            0:
            begin
                g1 = $urandom_range(1, 8);
                g2 = $urandom_range(1, 8);
                g3 = $urandom_range(1, 8);
            end
            1:
            begin
                g1 = $urandom_range(1, 1 << 19);
                g2 = $urandom_range(1, 1 << 19);
                g3 = $urandom_range(1, 1 << 19);
            end
            default:
            begin
                g1 = $urandom_range(1, 32'h3FFF_FFFF);
                g2 = $urandom_range(1, 32'h3FFF_FFFF);
                g3 = $urandom_range(1, 32'h3FFF_FFFF);
            end
        endcase
        base = longint'($signed($urandom));
        if (base + g1 + g2 + g3 > SMAX) base = SMAX - g1 - g2 - g3;
        tmp = '{base, base + g1, base + g1 + g2, base + g1 + g2 + g3};
        if ($urandom_range(0, 7) == 0)
        begin
            // break the order: swap the outer pair or make two knots equal
            if ($urandom_range(0, 1)) tmp[2] = tmp[1];
            else
            begin
                base = tmp[0];
                tmp[0] = tmp[3];
                tmp[3] = base;
            end
        end
        load_knots(tmp[0], tmp[1], tmp[2], tmp[3]);
    endtask

    // Position mostly inside the support, sometimes on a knot, sometimes anywhere.
    function automatic logic signed [qbsp_pkg::KNOT_W-1:0] pick_pos();
        longint lo, hi, span, off;
        int     sel;
        sel = $urandom_range(0, 9);
        lo  = knot_q[0];
        hi  = knot_q[3];
        if (lo > hi)
        begin
            lo = knot_q[3];
            hi = knot_q[0];
        end
        span = hi - lo + 2;
        if (sel < 7)
        begin
            off = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % span;
            off = lo - 1 + off;
            if (off > SMAX) off = SMAX;
            return off[qbsp_pkg::KNOT_W-1:0];
        end
        else if (sel == 7)
        begin
            return knot_q[$urandom_range(0, 3)][qbsp_pkg::KNOT_W-1:0];
        end
        return $urandom;
    endfunction

    // Directed stimulus table under the reset knots 0, 1.0, 2.0, 3.0.
    row_t dir_rows [14] = '{
        '{32'sh8000_0000, 1'b1, '{17'd0, 32'sd0, 1'b0}},
        '{32'sh7FFF_FFFF, 1'b1, '{17'd0, 32'sd0, 1'b0}},
        '{-32'sd1,        1'b1, '{17'd0, 32'sd0, 1'b0}},
        '{32'sh0000_0000, 1'b1, '{17'd0, 32'sd0, 1'b0}},
        '{32'sh0003_0000, 1'b1, '{17'd0, 32'sd0, 1'b0}},
        '{32'sh0000_0001, 1'b0, '{17'd0, 32'sd0, 1'b0}},
        '{32'sh0000_8000, 1'b0, '{17'd0, 32'sd0, 1'b0}},
        '{32'sh0000_FFFF, 1'b0, '{17'd0, 32'sd0, 1'b0}},
        '{32'sh0001_0000, 1'b0, '{17'd0, 32'sd0, 1'b0}},
        '{32'sh0001_8000, 1'b0, '{17'd0, 32'sd0, 1'b0}},
        '{32'sh0001_FFFF, 1'b0, '{17'd0, 32'sd0, 1'b0}},
        '{32'sh0002_0000, 1'b0, '{17'd0, 32'sd0, 1'b0}},
        '{32'sh0002_8000, 1'b0, '{17'd0, 32'sd0, 1'b0}},
        '{32'sh0002_FFFF, 1'b0, '{17'd0, 32'sd0, 1'b0}}
    };

    // Receiver side: random stall bursts, one long hold to back the pipeline up.
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held && beats_sent >= 400)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // Compare each result beat against the oldest expectation.
    always @(posedge clk)
    begin : score_blk
        basis_t exp_b;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_basis.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d slope=%0d bad=%0b", $realtime,
                         basis_value, basis_slope, knots_invalid);
                errors++;
            end
            else
            begin
                exp_b = pending_basis.pop_front();
                beats_checked++;
                if (basis_value !== exp_b.value)
                begin
                    $display("%0t: basis_value expected %0d actual %0d", $realtime,
                             exp_b.value, basis_value);
                    errors++;
                end
                if (basis_slope !== exp_b.slope)
                begin
                    $display("%0t: basis_slope expected %0d actual %0d", $realtime,
                             exp_b.slope, basis_slope);
                    errors++;
                end
                if (knots_invalid !== exp_b.bad)
                begin
                    $display("%0t: knots_invalid expected %0b actual %0b", $realtime,
                             exp_b.bad, knots_invalid);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a beat.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $realtime,
                     pending_basis.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        basis_t zero_b;
        basis_t bad_b;
        zero_b = '{17'd0, 32'sd0, 1'b0};
        bad_b  = '{17'd0, 32'sd0, 1'b1};
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = qbsp_pkg::REG_KNOT_ZERO;
        cfg_data     = '0;
        in_valid     = 1'b0;
        position     = '0;
        beats_sent   = 0;
        bad_phases   = 0;
        knot_sets    = 1;
        idle_on      = 1'b1;
        knot_q       = '{0, 64'sd1 <<< qbsp_pkg::FRAC_BITS, 64'sd2 <<< qbsp_pkg::FRAC_BITS,
                         64'sd3 <<< qbsp_pkg::FRAC_BITS};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table under the reset knots.
        foreach (dir_rows[i])
            send_pos(dir_rows[i].pos, dir_rows[i].typed, dir_rows[i].ans);

        // Equal knots: every position flags bad knots.
        load_knots(0, 0, 64'sd2 <<< qbsp_pkg::FRAC_BITS, 64'sd3 <<< qbsp_pkg::FRAC_BITS);
        send_pos(32'sh0000_0000, 1'b1, bad_b);
        send_pos(32'sh7FFF_FFFF, 1'b1, bad_b);
        // Descending knots.
        load_knots(64'sd3 <<< qbsp_pkg::FRAC_BITS, 64'sd2 <<< qbsp_pkg::FRAC_BITS,
                   64'sd1 <<< qbsp_pkg::FRAC_BITS, 0);
        send_pos(32'sh0001_8000, 1'b1, bad_b);
        // One-ulp spacing: the slope clamps.
        load_knots(0, 1, 2, 3);
        for (int p = -1; p <= 3; p++)
            send_pos(p, 1'b0, zero_b);
        // Knots at the ends of the range.
        load_knots(SMIN, -64'sd1, 64'sd1, SMAX);
        send_pos(32'sh8000_0000, 1'b0, zero_b);
        send_pos(32'sh0000_0000, 1'b0, zero_b);
        send_pos(32'sh7FFF_FFFE, 1'b0, zero_b);
        send_pos(32'sh7FFF_FFFF, 1'b1, zero_b);

        // Random phases, each under a fresh knot set; the last runs without idling.
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 9) idle_on = 1'b0;
            random_knots(ph % 3);
            repeat (122) send_pos(pick_pos(), 1'b0, zero_b);
        end

        in_valid <= 1'b0;
        wait (pending_basis.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);

        $display("Sent %0d positions across %0d knot sets (%0d with bad order).",
                 beats_sent, knot_sets, bad_phases);
        $display("Checked %0d results; long receiver hold %0s.", beats_checked,
                 held ? "done" : "skipped");
        if (errors == 0 && pending_basis.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/qbsp_pkg.sv
hdl/quadratic_bspline_basis_eval_top.sv
hdl/qbsp_checker.sv
bench/tb_top.sv
